// ===== rtl/trlc_pkg.sv =====
package trlc_pkg;

	localparam int ALPHA_LEN = 26;
	localparam int IDX_W = 5;
	localparam int CFG_IDX_W = 2;

	typedef logic [IDX_W-1:0] idx_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_FAST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MIDDLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SLOW   = 2'd2;

	localparam idx_t START_FAST_RST   = 5'd4;
	localparam idx_t START_MIDDLE_RST = 5'd0;
	localparam idx_t START_SLOW_RST   = 5'd1;

	localparam idx_t LAST_IDX = 5'd25;
	localparam logic [6:0] ASCII_A = 7'd65;

	typedef struct packed {
		idx_t fast_off;
		idx_t middle_off;
		idx_t slow_off;
		idx_t fast_cnt;
		idx_t middle_cnt;
	} rotor_state_t;

	typedef struct packed {
		idx_t fast;
		idx_t middle;
		idx_t slow;
	} start_letters_t;

	// forward wirings: letter index -> letter index
	localparam idx_t FAST_FWD [ALPHA_LEN] = '{
		5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
		5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
	localparam idx_t MIDDLE_FWD [ALPHA_LEN] = '{
		5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
		5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
	localparam idx_t SLOW_FWD [ALPHA_LEN] = '{
		5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
		5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
	localparam idx_t REFLECT_B [ALPHA_LEN] = '{
		5'd5, 5'd21, 5'd15, 5'd9, 5'd8, 5'd0, 5'd14, 5'd24, 5'd4, 5'd3, 5'd17, 5'd25, 5'd23,
		5'd22, 5'd6, 5'd2, 5'd19, 5'd10, 5'd20, 5'd16, 5'd18, 5'd1, 5'd13, 5'd12, 5'd7, 5'd11};

	// inverse wirings: letter index -> position in the wiring
	localparam idx_t FAST_INV [ALPHA_LEN] = '{
		5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
		5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
	localparam idx_t MIDDLE_INV [ALPHA_LEN] = '{
		5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
		5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
	localparam idx_t SLOW_INV [ALPHA_LEN] = '{
		5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
		5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};

	function automatic idx_t add_mod(idx_t a, idx_t b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(ALPHA_LEN)) begin
			s = s - (IDX_W+1)'(ALPHA_LEN);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t sub_mod(idx_t a, idx_t b);
		logic [IDX_W:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + (IDX_W+1)'(ALPHA_LEN) - {1'b0, b};
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/trlc_path.sv =====
module trlc_path (
	input  logic                    action,
	input  logic [7:0]              char_in,
	input  trlc_pkg::rotor_state_t  state,
	input  trlc_pkg::start_letters_t start,
	output logic [6:0]              letter_out,
	output logic                    bad_char,
	output trlc_pkg::rotor_state_t  state_nxt
);
	import trlc_pkg::*;

	logic is_letter;
	idx_t p0, p1, p2, p3, p4, p5, p6, p7;
	rotor_state_t stepped;

	// upper and lower case share the low five bits: A/a = 1 .. Z/z = 26
	assign is_letter = (char_in[7:6] == 2'b01) && (char_in[4:0] != 5'd0)
		&& (char_in[4:0] <= 5'd26);
	assign p0 = char_in[4:0] - 5'd1;

	assign p1 = FAST_FWD[add_mod(p0, state.fast_off)];
	assign p2 = MIDDLE_FWD[add_mod(p1, state.middle_off)];
	assign p3 = SLOW_FWD[add_mod(p2, state.slow_off)];
	assign p4 = REFLECT_B[p3];
	assign p5 = sub_mod(SLOW_INV[p4], state.slow_off);
	assign p6 = sub_mod(MIDDLE_INV[p5], state.middle_off);
	assign p7 = sub_mod(FAST_INV[p6], state.fast_off);

	// odometer step: middle carries when the fast counter wraps, slow on middle wrap
	always_comb begin
		stepped = state;
		stepped.fast_off = add_mod(state.fast_off, 5'd1);
		if (state.fast_cnt >= LAST_IDX) begin
			stepped.fast_cnt = '0;
			stepped.middle_off = add_mod(state.middle_off, 5'd1);
			if (state.middle_cnt >= LAST_IDX) begin
				stepped.middle_cnt = '0;
				stepped.slow_off = add_mod(state.slow_off, 5'd1);
			end else begin
				stepped.middle_cnt = state.middle_cnt + 5'd1;
			end
		end else begin
			stepped.fast_cnt = state.fast_cnt + 5'd1;
		end
	end

	always_comb begin
		letter_out = '0;
		bad_char = 1'b0;
		state_nxt = state;
		priority if (action) begin
			state_nxt.fast_off = (start.fast <= LAST_IDX) ? FAST_INV[start.fast] : '0;
			state_nxt.middle_off = (start.middle <= LAST_IDX) ? MIDDLE_INV[start.middle] : '0;
			state_nxt.slow_off = (start.slow <= LAST_IDX) ? SLOW_INV[start.slow] : '0;
			state_nxt.fast_cnt = '0;
			state_nxt.middle_cnt = '0;
		end else if (!is_letter) begin
			bad_char = 1'b1;
		end else begin
			letter_out = ASCII_A + {2'b00, p7};
			state_nxt = stepped;
		end
	end

endmodule

// ===== rtl/three_rotor_letter_cipher_unit.sv =====
// Input register, then result register, with the whole rotor path between them.
// Throughput: one character per cycle unless out_stall holds the result register;
// the rotor offsets update in the same cycle the result is registered, so the next
// character sees them at once.
// Reset (arst_n low, asynchronous): offsets and counters cleared, start letters 4/0/1.
module three_rotor_letter_cipher_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] letter_out,
	output logic       bad_char,
	input  logic       cfg_we,
	input  logic [trlc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trlc_pkg::IDX_W-1:0]     cfg_data
);
	import trlc_pkg::*;

	logic valid_s1;
	logic action_s1;
	logic [7:0] char_s1;
	logic out_valid_q;
	logic [6:0] letter_q;
	logic bad_q;
	rotor_state_t state_q;
	rotor_state_t state_nxt;
	start_letters_t start_q;
	logic advance;
	logic [6:0] letter_c;
	logic bad_c;

	// move s1 into the result register when the result slot is free or draining
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	trlc_path u_path (
		.action     (action_s1),
		.char_in    (char_s1),
		.state      (state_q),
		.start      (start_q),
		.letter_out (letter_c),
		.bad_char   (bad_c),
		.state_nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			char_s1 <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q <= state_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			letter_q <= letter_c;
			bad_q <= bad_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q.fast <= START_FAST_RST;
			start_q.middle <= START_MIDDLE_RST;
			start_q.slow <= START_SLOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_FAST:   start_q.fast <= cfg_data;
				CFG_START_MIDDLE: start_q.middle <= cfg_data;
				CFG_START_SLOW:   start_q.slow <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign letter_out = letter_q;
	assign bad_char = bad_q;

endmodule
